### src/hsmh_pkg.sv
// shared constants and types for the heapsort block
// no dependencies; imported by hsmh_oreg, heapsort_max_heap and hsmh_chk
package hsmh_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CH_W       = ADDR_W + 2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      data_type value;
      logic     end_of_run;
      logic     overflowed;
   } rsp_type;

endpackage

### src/hsmh_ram.sv
// simple dual-port ram: one write port, one read port with registered data
// no dependencies
module hsmh_ram #(
   parameter int DEPTH_P = 64,
   parameter int WIDTH_P = 32
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH_P)-1:0] waddr,
   input  logic [WIDTH_P-1:0]         wdata,
   input  logic                       re,
   input  logic [$clog2(DEPTH_P)-1:0] raddr,
   output logic [WIDTH_P-1:0]         rdata
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/hsmh_oreg.sv
// result output register, frees itself on the cycle the result is taken
// depends on hsmh_pkg
module hsmh_oreg import hsmh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free     = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### src/heapsort_max_heap.sv
// heapsort top level: load sequencer, heap sift engine and emit pass over one ram
// depends on hsmh_pkg, hsmh_ram, hsmh_oreg
//
//  channel | signals                                        | direction
//  req     | req_valid req_ready req_value req_is_last      | in
//  rsp     | rsp_valid rsp_ready rsp_sorted_value           | out
//          | rsp_end_of_run rsp_overflowed                  |
//
// load: one request per cycle, written to the ram at the fill count unless full.
// sort: each sift level reads the left child, reads the right child, then compares
//   and writes; the single ram read port keeps the two child reads apart. emission
//   reads each result from the ram, then loads it into the free output register.
// reset clears control state only; ram contents are undefined, and no clearing pass.
// a stalled result holds in the output register; requests are taken again as
//   soon as the final result of a set is loaded into it.
module heapsort_max_heap import hsmh_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_end_of_run,
   output logic                         rsp_overflowed
);

   typedef enum logic [10:0] {
      S_LOAD = 11'b00000000001,
      S_NODE = 11'b00000000010,
      S_NV   = 11'b00000000100,
      S_CHK  = 11'b00000001000,
      S_RDR  = 11'b00000010000,
      S_CMP  = 11'b00000100000,
      S_XA   = 11'b00001000000,
      S_XB   = 11'b00010000000,
      S_XC   = 11'b00100000000,
      S_ERD  = 11'b01000000000,
      S_EOUT = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] node_ff, node_in;
   logic [ADDR_W-1:0] e_ff, e_in;
   logic             build_ff, build_in;
   data_type         nv_ff, nv_in;
   data_type         lv_ff, lv_in;

   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   data_type              rd_val;

   logic [CH_W-1:0]  lc, rc;
   logic             lc_ok, rc_ok;
   logic             accept, store_ok, sift_done;
   logic [CNT_W-1:0] n_new, n_half;
   logic [CH_W-1:0]  big_idx;
   data_type         big_val;
   logic             moved;
   logic             out_free, out_load;
   rsp_type          out_load_data, out_data;

   assign rd_val = signed'(ram_rdata);
   assign lc     = CH_W'({node_ff, 1'b0}) + CH_W'(1);
   assign rc     = lc + CH_W'(1);
   assign lc_ok  = lc < CH_W'(len_ff);
   assign rc_ok  = rc < CH_W'(len_ff);

   assign req_ready = (state_ff == S_LOAD);
   assign accept    = req_valid && req_ready;
   assign store_ok  = (cnt_ff != CNT_W'(DEPTH));
   assign n_new     = cnt_ff + CNT_W'(store_ok);
   assign n_half    = n_new >> 1;

   // larger of node, left and right; ties keep the earlier candidate
   always_comb begin
      if (lv_ff > nv_ff) begin
         big_idx = lc;
         big_val = lv_ff;
         moved   = 1'b1;
      end else begin
         big_idx = CH_W'(node_ff);
         big_val = nv_ff;
         moved   = 1'b0;
      end
      if (rc_ok && (rd_val > big_val)) begin
         big_idx = rc;
         big_val = rd_val;
         moved   = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      len_in    = len_ff;
      k_in      = k_ff;
      node_in   = node_ff;
      e_in      = e_ff;
      build_in  = build_ff;
      nv_in     = nv_ff;
      lv_in     = lv_ff;
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = nv_ff;
      ram_re    = 1'b0;
      ram_raddr = node_ff;
      sift_done = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               ram_we    = store_ok;
               ram_waddr = cnt_ff[ADDR_W-1:0];
               ram_wdata = req_value;
               cnt_in    = n_new;
               if (!store_ok) begin
                  ovf_in = 1'b1;
               end
               if (req_is_last) begin
                  len_in = n_new;
                  e_in   = '0;
                  if (n_new < CNT_W'(2)) begin
                     state_in = S_ERD;
                  end else begin
                     k_in     = ADDR_W'(n_half - CNT_W'(1));
                     node_in  = ADDR_W'(n_half - CNT_W'(1));
                     build_in = 1'b1;
                     state_in = S_NODE;
                  end
               end
            end
         end
         S_NODE: begin
            ram_re    = 1'b1;
            ram_raddr = node_ff;
            state_in  = S_NV;
         end
         S_NV: begin
            nv_in    = rd_val;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (lc_ok) begin
               ram_re    = 1'b1;
               ram_raddr = lc[ADDR_W-1:0];
               state_in  = S_RDR;
            end else begin
               ram_we    = 1'b1;
               sift_done = 1'b1;
            end
         end
         S_RDR: begin
            lv_in     = rd_val;
            ram_re    = rc_ok;
            ram_raddr = rc[ADDR_W-1:0];
            state_in  = S_CMP;
         end
         S_CMP: begin
            ram_we = 1'b1;
            if (moved) begin
               // child moves up, held value keeps sinking
               ram_wdata = big_val;
               node_in   = big_idx[ADDR_W-1:0];
               state_in  = S_CHK;
            end else begin
               sift_done = 1'b1;
            end
         end
         S_XA: begin
            ram_re    = 1'b1;
            ram_raddr = k_ff;
            state_in  = S_XB;
         end
         S_XB: begin
            nv_in     = rd_val;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_in  = S_XC;
         end
         S_XC: begin
            // old root goes to the end of the shrinking heap
            ram_we    = 1'b1;
            ram_waddr = k_ff;
            ram_wdata = ram_rdata;
            node_in   = '0;
            len_in    = CNT_W'(k_ff);
            state_in  = S_CHK;
         end
         S_ERD: begin
            ram_re    = 1'b1;
            ram_raddr = e_ff;
            state_in  = S_EOUT;
         end
         S_EOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (CNT_W'(e_ff) + CNT_W'(1) == cnt_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  e_in     = e_ff + ADDR_W'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (sift_done) begin
         if (build_ff) begin
            if (k_ff == '0) begin
               build_in = 1'b0;
               k_in     = ADDR_W'(len_ff - CNT_W'(1));
               state_in = S_XA;
            end else begin
               k_in     = k_ff - ADDR_W'(1);
               node_in  = k_ff - ADDR_W'(1);
               state_in = S_NODE;
            end
         end else begin
            if (k_ff == ADDR_W'(1)) begin
               e_in     = '0;
               state_in = S_ERD;
            end else begin
               k_in     = k_ff - ADDR_W'(1);
               state_in = S_XA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      k_ff     <= k_in;
      node_ff  <= node_in;
      e_ff     <= e_in;
      build_ff <= build_in;
      nv_ff    <= nv_in;
      lv_ff    <= lv_in;
   end

   hsmh_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (DATA_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_load_data.value      = rd_val;
   assign out_load_data.end_of_run = (CNT_W'(e_ff) + CNT_W'(1) == cnt_ff);
   assign out_load_data.overflowed = ovf_ff;

   hsmh_oreg u_oreg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_load_data),
      .free      (out_free),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_sorted_value = out_data.value;
   assign rsp_end_of_run   = out_data.end_of_run;
   assign rsp_overflowed   = out_data.overflowed;

endmodule

### src/hsmh_chk.sv
// port-level checks for the heapsort block, bound to the top level
// depends on hsmh_pkg
module hsmh_chk import hsmh_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_is_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   input logic                         rsp_end_of_run,
   input logic                         rsp_overflowed
);

   // a stalled result keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sorted_value) && $stable(rsp_end_of_run)
         && $stable(rsp_overflowed))
      else $error("rsp payload changed while stalled");

   // the last request of a set ends loading, no further request is taken
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("request taken right after end of set");

   // the overflow flag is the same on every result of one set
   a_ovf_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end_of_run |=>
         !rsp_valid || (rsp_overflowed == $past(rsp_overflowed)))
      else $error("overflow flag changed within a set");

endmodule

bind heapsort_max_heap hsmh_chk u_chk (.*);
